### rtl/keypad_combination_lock_top_defines.svh
// Assertion macros for the keypad combination lock RTL.
// Used by kcl_core; expects clk and rst_n in the scope of each use.
`ifndef KEYPAD_COMBINATION_LOCK_TOP_DEFINES_SVH
`define KEYPAD_COMBINATION_LOCK_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define KCL_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("kcl: assertion failed");
`define KCL_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("kcl: forbidden condition seen");
`else
`define KCL_ASSERT(label, prop)
`define KCL_NEVER(label, expr)
`endif

`endif

### rtl/kcl_pkg.sv
// Shared types, codes and helpers for the keypad combination lock.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package kcl_pkg;

    localparam logic [1:0] MODE_OPEN   = 2'd0;
    localparam logic [1:0] MODE_CLOSED = 2'd1;
    localparam logic [1:0] MODE_LOCKED = 2'd2;
    localparam logic [1:0] MODE_MASTER = 2'd3;

    localparam logic [1:0] MOTOR_NONE  = 2'd0;
    localparam logic [1:0] MOTOR_CLOSE = 2'd1;
    localparam logic [1:0] MOTOR_OPEN  = 2'd2;

    localparam logic [1:0] VERDICT_NONE = 2'd0;
    localparam logic [1:0] VERDICT_OK   = 2'd1;
    localparam logic [1:0] VERDICT_BAD  = 2'd2;

    localparam logic       OP_KEY     = 1'b0;
    localparam logic       OP_RELEASE = 1'b1;

    localparam logic [7:0] KEY_0    = 8'h30;
    localparam logic [7:0] KEY_9    = 8'h39;
    localparam logic [7:0] KEY_HASH = 8'h23;

    localparam logic [2:0] CODE_DIGITS = 3'd4;
    localparam logic [3:0] FAIL_SAT    = 4'hF;

    localparam logic [15:0] MASTER_CODE_RST = 16'h1234;
    localparam logic [3:0]  MAX_FAIL_RST    = 4'd3;

    localparam logic REG_MASTER_CODE  = 1'b0;
    localparam logic REG_MAX_FAILURES = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] key_char;
    } item_t;

    typedef struct packed {
        logic [15:0] master_code;
        logic [3:0]  max_failures;
    } cfg_t;

    // lock_mode ends up in the lowest bits
    typedef struct packed {
        logic [1:0] verdict;
        logic [3:0] failed_attempts;
        logic [2:0] digits_entered;
        logic [1:0] motor_command;
        logic [1:0] lock_mode;
    } result_t;

    // first digit goes into the top nibble
    function automatic logic [15:0] put_digit(input logic [15:0] code,
                                              input logic [1:0]  pos,
                                              input logic [3:0]  digit);
        logic [15:0] res;
        res = code;
        case (pos)
            2'd0:    res[15:12] = digit;
            2'd1:    res[11:8]  = digit;
            2'd2:    res[7:4]   = digit;
            default: res[3:0]   = digit;
        endcase
        return res;
    endfunction

endpackage

### rtl/kcl_cfg.sv
// APB register file of the keypad combination lock: master code, failure limit.
// Depends on kcl_pkg.
`timescale 1ns / 1ps

module kcl_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output kcl_pkg::cfg_t      cfg
);
    import kcl_pkg::*;

    logic [15:0] master_code_reg;
    logic [3:0]  max_failures_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_code_reg  <= MASTER_CODE_RST;
            max_failures_reg <= MAX_FAIL_RST;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_MASTER_CODE)
                master_code_reg <= pwdata[15:0];
            else
                max_failures_reg <= pwdata[3:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_MASTER_CODE)
            prdata = {16'd0, master_code_reg};
        else
            prdata = {28'd0, max_failures_reg};
    end

    assign cfg.master_code  = master_code_reg;
    assign cfg.max_failures = max_failures_reg;

endmodule

### rtl/kcl_in_reg.sv
// Input register of the keypad combination lock: holds one key word.
// Depends on kcl_pkg.
`timescale 1ns / 1ps

module kcl_in_reg
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  kcl_pkg::item_t in_item,
    output logic           item_valid,
    input  logic           item_take,
    output kcl_pkg::item_t item
);
    import kcl_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign in_ready   = !valid_reg || item_take;
    assign load       = in_valid && in_ready;
    assign valid_next = load ? 1'b1 : (item_take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= in_item;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/kcl_core.sv
// Lock state and single-pass update logic for one key word.
// Depends on kcl_pkg and keypad_combination_lock_top_defines.svh.
`timescale 1ns / 1ps
`include "keypad_combination_lock_top_defines.svh"

module kcl_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  kcl_pkg::item_t   item,
    input  kcl_pkg::cfg_t    cfg,
    output kcl_pkg::result_t res
);
    import kcl_pkg::*;

    logic [1:0]  mode_reg;
    logic [1:0]  mode_next;
    logic [2:0]  digit_count_reg;
    logic [2:0]  digit_count_next;
    logic [3:0]  failure_count_reg;
    logic [3:0]  failure_count_next;
    logic [15:0] user_code_reg;
    logic [15:0] user_code_next;
    logic [15:0] entry_code_reg;
    logic [15:0] entry_code_next;

    logic        is_digit;
    logic [3:0]  digit;
    logic        room;
    logic [15:0] entry_upd;
    logic [2:0]  count_upd;
    logic [15:0] target;
    logic [3:0]  fail_inc;
    logic [1:0]  motor;
    logic [1:0]  verdict;

    assign is_digit  = (item.key_char >= KEY_0) && (item.key_char <= KEY_9);
    assign digit     = item.key_char[3:0];
    assign room      = digit_count_reg < CODE_DIGITS;
    assign entry_upd = room ? put_digit(entry_code_reg, digit_count_reg[1:0], digit)
                            : entry_code_reg;
    assign count_upd = room ? digit_count_reg + 3'd1 : digit_count_reg;
    assign target    = (mode_reg == MODE_CLOSED) ? user_code_reg : cfg.master_code;
    assign fail_inc  = (failure_count_reg < FAIL_SAT) ? failure_count_reg + 4'd1
                                                      : failure_count_reg;

    always_comb
    begin
        mode_next          = mode_reg;
        digit_count_next   = digit_count_reg;
        failure_count_next = failure_count_reg;
        user_code_next     = user_code_reg;
        entry_code_next    = entry_code_reg;
        motor              = MOTOR_NONE;
        verdict            = VERDICT_NONE;

        if (item.opcode == OP_RELEASE)
        begin
            if (mode_reg == MODE_LOCKED)
            begin
                mode_next        = MODE_MASTER;
                digit_count_next = 3'd0;
                entry_code_next  = 16'd0;
            end
        end
        else
        begin
            case (mode_reg)
                MODE_OPEN:
                begin
                    if (is_digit)
                    begin
                        if (room)
                        begin
                            user_code_next   = put_digit(user_code_reg,
                                                         digit_count_reg[1:0], digit);
                            digit_count_next = count_upd;
                        end
                    end
                    else if (item.key_char == KEY_HASH && !room)
                    begin
                        mode_next          = MODE_CLOSED;
                        digit_count_next   = 3'd0;
                        failure_count_next = 4'd0;
                        motor              = MOTOR_CLOSE;
                    end
                end
                MODE_CLOSED, MODE_MASTER:
                begin
                    if (is_digit)
                    begin
                        if (count_upd >= CODE_DIGITS)
                        begin
                            digit_count_next = 3'd0;
                            entry_code_next  = 16'd0;
                            if (entry_upd == target)
                            begin
                                mode_next      = MODE_OPEN;
                                user_code_next = 16'd0;
                                motor          = MOTOR_OPEN;
                                verdict        = VERDICT_OK;
                            end
                            else
                            begin
                                verdict = VERDICT_BAD;
                                if (mode_reg == MODE_CLOSED)
                                begin
                                    failure_count_next = fail_inc;
                                    if (fail_inc >= cfg.max_failures)
                                        mode_next = MODE_LOCKED;
                                end
                                else
                                begin
                                    mode_next = MODE_LOCKED;
                                end
                            end
                        end
                        else
                        begin
                            entry_code_next  = entry_upd;
                            digit_count_next = count_upd;
                        end
                    end
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_OPEN;
            digit_count_reg   <= 3'd0;
            failure_count_reg <= 4'd0;
        end
        else if (step)
        begin
            mode_reg          <= mode_next;
            digit_count_reg   <= digit_count_next;
            failure_count_reg <= failure_count_next;
        end
    end

    // code stores are defined once written
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            user_code_reg  <= user_code_next;
            entry_code_reg <= entry_code_next;
        end
    end

    assign res.lock_mode       = mode_next;
    assign res.motor_command   = motor;
    assign res.digits_entered  = digit_count_next;
    assign res.failed_attempts = failure_count_next;
    assign res.verdict         = verdict;

    `KCL_NEVER(a_count_range, digit_count_reg > CODE_DIGITS)
    `KCL_NEVER(a_entry_never_full, (mode_reg == MODE_CLOSED || mode_reg == MODE_MASTER) && digit_count_reg == CODE_DIGITS)
    `KCL_ASSERT(a_open_after_match, step && motor == MOTOR_OPEN |=> mode_reg == MODE_OPEN && digit_count_reg == 3'd0)
    `KCL_ASSERT(a_close_clears_fail, step && motor == MOTOR_CLOSE |=> mode_reg == MODE_CLOSED && failure_count_reg == 4'd0)

endmodule

### rtl/kcl_out_reg.sv
// Result register of the keypad combination lock: holds one result word.
// Depends on kcl_pkg.
`timescale 1ns / 1ps

module kcl_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    output logic             can_load,
    input  kcl_pkg::result_t res,
    output logic             out_valid,
    input  logic             out_ready,
    output kcl_pkg::result_t out_res
);
    import kcl_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

### rtl/keypad_combination_lock_top.sv
// Keypad combination lock: safe-lock controller fed by decoded key words.
// Slave stream carries key words in, master stream carries one status word per key
// word. APB port sets the master code (0x0) and the failure limit (0x4).
// A status word reaches the master side after its key word is accepted, passing
// through the input register, then the update logic into the result register.
// Throughput: one word per cycle while m_tready is high; the lock state is
// updated in the same cycle the word passes from the input register to the
// result register. When the master side stalls, the result word holds and s_tready
// drops once the input register is also full; no word is lost or repeated.
// Reset: both stream stages empty, safe open with no digits and no failures,
// master code 0x1234, failure limit 3. The user and entry code registers hold
// no defined value until written.
// Depends on kcl_pkg and all kcl_* modules.
`timescale 1ns / 1ps

module keypad_combination_lock_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_char
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] lock_mode, [3:2] motor_command,
                                   // [6:4] digits_entered, [10:7] failed_attempts,
                                   // [12:11] verdict, [15:13] zero
);
    import kcl_pkg::*;

    cfg_t    cfg;
    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    can_load;
    logic    step;
    result_t res;
    result_t out_res;

    assign in_item.opcode   = s_tuser[0];
    assign in_item.key_char = s_tdata;
    assign step             = item_valid && can_load;

    kcl_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kcl_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (step),
        .item       (item)
    );

    kcl_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item),
        .cfg   (cfg),
        .res   (res)
    );

    kcl_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .can_load  (can_load),
        .res       (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {3'd0, out_res};

endmodule
